@@ rtl/bbag_pkg.sv @@
`timescale 1ns / 1ps

package bbag_pkg;

  // Screen size that destination rectangles are clipped against.
  localparam logic [12:0] SCREEN_W = 13'd320;
  localparam logic [12:0] SCREEN_H = 13'd240;

  // Reset values of the bitmap size registers.
  localparam logic [11:0] BITMAP_W_RST = 12'd320;
  localparam logic [11:0] BITMAP_H_RST = 12'd240;

  typedef enum logic [0:0] {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_SOLID    = 2'd0,
    MODE_REPEAT   = 2'd1,
    MODE_ADAPTIVE = 2'd2,
    MODE_NONE     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_BITMAP_WIDTH  = 2'd0,
    CFG_BITMAP_HEIGHT = 2'd1
  } cfg_reg_e;

  // Clipped span: position is never negative, length may be zero or negative.
  typedef struct packed {
    logic signed [13:0] pos;
    logic signed [13:0] len;
  } span_t;

  // Clamp a negative start to zero and cut the length at the far edge.
  function automatic span_t clip_span(logic signed [11:0] pos, logic signed [11:0] len,
                                      logic [12:0] limit);
    span_t              res;
    logic signed [13:0] lim;
    logic signed [13:0] ends;
    lim     = $signed({1'b0, limit});
    res.pos = (pos < 0) ? 14'sd0 : 14'(pos);
    res.len = 14'(len);
    ends    = res.pos + res.len;
    if (ends > lim) begin
      res.len = lim - res.pos;
    end
    return res;
  endfunction

endpackage

@@ rtl/bitmap_blit_address_generator.sv @@
`timescale 1ns / 1ps

// A step beat shows its pixel on the output in the cycle after it is accepted.
// Throughput: one beat per cycle; a start beat gives no pixel.
// The input is stalled only while the output register holds a pixel not yet taken.
// Reset: the block is idle, the output is empty and the bitmap size is 320 by 240.
// The one 12 by 12 multiplier (row times stride) sits in the start and stride write path.
module bitmap_blit_address_generator (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [11:0]        cfg_data_i,
  // Command channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [1:0]         draw_mode_i,
  input  logic signed [11:0] dest_left_i,
  input  logic signed [11:0] dest_top_i,
  input  logic signed [11:0] dest_width_i,
  input  logic signed [11:0] dest_height_i,
  input  logic signed [11:0] source_left_i,
  input  logic signed [11:0] source_top_i,
  input  logic signed [11:0] source_width_i,
  input  logic signed [11:0] source_height_i,
  // Pixel channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [23:0]        source_address_o,
  output logic [11:0]        screen_x_o,
  output logic [11:0]        screen_y_o,
  output logic               last_pixel_o
);

  // Configuration registers
  logic [11:0] bitmap_width_q, bitmap_height_q;

  // Draw state
  logic        active_q, active_d;
  logic [11:0] origin_x_q, origin_y_q;
  logic [11:0] span_cols_q, span_rows_q;
  logic [11:0] tile_cols_q, tile_rows_q;
  logic [11:0] src_col_base_q, src_row_start_q;
  logic [11:0] row_count_q, row_count_d;
  logic [11:0] col_count_q, col_count_d;
  logic [11:0] tile_col_q, tile_col_d;
  logic [11:0] tile_row_q, tile_row_d;
  logic [23:0] row_base_q, row_base_d;
  logic [23:0] row_start_addr_q;

  // Output register
  logic        out_valid_q;
  logic [23:0] src_addr_q;
  logic [11:0] scr_x_q, scr_y_q;
  logic        last_q;

  logic        in_fire, start_fire, step_fire, width_wr, height_wr;
  logic        draw_ok;
  bbag_pkg::span_t dx, dy, sx, sy;
  logic [11:0] cols_w, rows_w, tcols_w, trows_w;
  logic [11:0] mul_a, mul_b;
  logic [23:0] mul_prod;
  logic [12:0] col_inc, row_inc, tcol_inc, trow_inc;
  logic        row_end, last_w;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign start_fire  = in_fire && (command_i == bbag_pkg::CMD_START);
  assign step_fire   = in_fire && (command_i == bbag_pkg::CMD_STEP) && active_q;

  // Register index decode
  always_comb begin
    width_wr  = 1'b0;
    height_wr = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bbag_pkg::CFG_BITMAP_WIDTH:  width_wr  = 1'b1;
        bbag_pkg::CFG_BITMAP_HEIGHT: height_wr = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitmap_width_q  <= bbag_pkg::BITMAP_W_RST;
      bitmap_height_q <= bbag_pkg::BITMAP_H_RST;
    end else begin
      if (width_wr) begin
        bitmap_width_q <= cfg_data_i;
      end
      if (height_wr) begin
        bitmap_height_q <= cfg_data_i;
      end
    end
  end

  // Clip both rectangles and pick the walk and tile sizes for the mode.
  always_comb begin
    dx = bbag_pkg::clip_span(dest_left_i, dest_width_i, bbag_pkg::SCREEN_W);
    dy = bbag_pkg::clip_span(dest_top_i, dest_height_i, bbag_pkg::SCREEN_H);
    sx = bbag_pkg::clip_span(source_left_i, source_width_i, {1'b0, bitmap_width_q});
    sy = bbag_pkg::clip_span(source_top_i, source_height_i, {1'b0, bitmap_height_q});
    draw_ok = ((draw_mode_i == bbag_pkg::MODE_SOLID) || (draw_mode_i == bbag_pkg::MODE_REPEAT))
              && (dx.len > 0) && (dy.len > 0) && (sx.len > 0) && (sy.len > 0);
    tcols_w = sx.len[11:0];
    trows_w = sy.len[11:0];
    cols_w  = dx.len[11:0];
    rows_w  = dy.len[11:0];
    if (draw_mode_i == bbag_pkg::MODE_SOLID) begin
      if (sx.len < dx.len) begin
        cols_w = sx.len[11:0];
      end
      if (sy.len < dy.len) begin
        rows_w = sy.len[11:0];
      end
      tcols_w = cols_w;
      trows_w = rows_w;
    end
  end

  // Shared multiplier: first source row times the stride, on start or stride write.
  assign mul_a    = start_fire ? sy.pos[11:0] : src_row_start_q;
  assign mul_b    = width_wr ? cfg_data_i : bitmap_width_q;
  assign mul_prod = 24'(mul_a) * 24'(mul_b);

  // Row-major walk with wrapping tile counters.
  always_comb begin
    col_inc  = {1'b0, col_count_q} + 13'd1;
    row_inc  = {1'b0, row_count_q} + 13'd1;
    tcol_inc = {1'b0, tile_col_q} + 13'd1;
    trow_inc = {1'b0, tile_row_q} + 13'd1;
    row_end  = (col_inc == {1'b0, span_cols_q});
    last_w   = row_end && (row_inc == {1'b0, span_rows_q});

    active_d    = active_q;
    col_count_d = col_count_q;
    row_count_d = row_count_q;
    tile_col_d  = tile_col_q;
    tile_row_d  = tile_row_q;
    row_base_d  = row_base_q;

    if (start_fire) begin
      active_d    = draw_ok;
      col_count_d = '0;
      row_count_d = '0;
      tile_col_d  = '0;
      tile_row_d  = '0;
      row_base_d  = mul_prod;
    end else if (step_fire) begin
      if (last_w) begin
        active_d = 1'b0;
      end else if (row_end) begin
        col_count_d = '0;
        tile_col_d  = '0;
        row_count_d = row_inc[11:0];
        if (trow_inc >= {1'b0, tile_rows_q}) begin
          tile_row_d = '0;
          row_base_d = row_start_addr_q;
        end else begin
          tile_row_d = trow_inc[11:0];
          row_base_d = row_base_q + 24'(bitmap_width_q);
        end
      end else begin
        col_count_d = col_inc[11:0];
        tile_col_d  = (tcol_inc >= {1'b0, tile_cols_q}) ? 12'd0 : tcol_inc[11:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q         <= 1'b0;
      origin_x_q       <= '0;
      origin_y_q       <= '0;
      span_cols_q      <= '0;
      span_rows_q      <= '0;
      tile_cols_q      <= '0;
      tile_rows_q      <= '0;
      src_col_base_q   <= '0;
      src_row_start_q  <= '0;
      row_count_q      <= '0;
      col_count_q      <= '0;
      tile_col_q       <= '0;
      tile_row_q       <= '0;
      row_base_q       <= '0;
      row_start_addr_q <= '0;
    end else begin
      active_q    <= active_d;
      row_count_q <= row_count_d;
      col_count_q <= col_count_d;
      tile_col_q  <= tile_col_d;
      tile_row_q  <= tile_row_d;
      row_base_q  <= row_base_d;
      if (start_fire && draw_ok) begin
        origin_x_q      <= dx.pos[11:0];
        origin_y_q      <= dy.pos[11:0];
        span_cols_q     <= cols_w;
        span_rows_q     <= rows_w;
        tile_cols_q     <= tcols_w;
        tile_rows_q     <= trows_w;
        src_col_base_q  <= sx.pos[11:0];
        src_row_start_q <= sy.pos[11:0];
      end
      // A new stride also moves the address that a tile wraps back to.
      if ((start_fire && draw_ok) || width_wr) begin
        row_start_addr_q <= mul_prod;
      end
    end
  end

  // Output register: loaded with one pixel beat per accepted step while a draw is active.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= step_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      src_addr_q <= row_base_q + 24'(src_col_base_q) + 24'(tile_col_q);
      scr_x_q    <= origin_x_q + col_count_q;
      scr_y_q    <= origin_y_q + row_count_q;
      last_q     <= last_w;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign source_address_o = src_addr_q;
  assign screen_x_o       = scr_x_q;
  assign screen_y_o       = scr_y_q;
  assign last_pixel_o     = last_q;

  // The walk never runs past its row or its tile.
  a_col_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (col_count_q < span_cols_q) && (row_count_q < span_rows_q))
    else $error("column or row count ran past the span");

  a_tile_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (tile_col_q < tile_cols_q) && (tile_row_q < tile_rows_q))
    else $error("tile counter ran past the tile size");

  // The final pixel of a draw leaves the block idle.
  a_last_ends_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && last_w) |=> !active_q)
    else $error("draw still active after its last pixel");

  // A start beat never produces a pixel beat.
  a_start_no_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_fire |=> !out_valid_q)
    else $error("start beat produced a pixel");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

  // Register indexes outside the implemented map; writes to them must be ignored.
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  localparam int HOLD_OFF_CYCLES = 250;

  typedef struct {
    bbag_pkg::cmd_e     cmd;
    bbag_pkg::mode_e    mode;
    logic signed [11:0] dl, dt, dw, dh;
    logic signed [11:0] sl, st, sw, sh;
  } blit_cmd_t;

  typedef struct {
    logic [23:0] addr;
    logic [11:0] x;
    logic [11:0] y;
    logic        last;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;
  logic        cfg_ready_o;

  logic               in_valid = 1'b0;
  logic               in_ready_o;
  logic               command = 1'b0;
  logic [1:0]         draw_mode = '0;
  logic signed [11:0] dest_left = '0, dest_top = '0, dest_width = '0, dest_height = '0;
  logic signed [11:0] source_left = '0, source_top = '0, source_width = '0;
  logic signed [11:0] source_height = '0;

  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [23:0] source_address_o;
  logic [11:0] screen_x_o, screen_y_o;
  logic        last_pixel_o;

  bitmap_blit_address_generator uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .command_i       (command),
    .draw_mode_i     (draw_mode),
    .dest_left_i     (dest_left),
    .dest_top_i      (dest_top),
    .dest_width_i    (dest_width),
    .dest_height_i   (dest_height),
    .source_left_i   (source_left),
    .source_top_i    (source_top),
    .source_width_i  (source_width),
    .source_height_i (source_height),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .source_address_o(source_address_o),
    .screen_x_o      (screen_x_o),
    .screen_y_o      (screen_y_o),
    .last_pixel_o    (last_pixel_o)
  );

  // 12 ns clock period.
  always #6 clk_i = ~clk_i;

  blit_cmd_t pending_cmds[$];
  pixel_t    expected_pixels[$];
  int        mismatch_count = 0;
  bit        calm = 1'b0;
  bit        sender_busy = 1'b0;

  // Shadow copy of the bitmap size registers and the draw state.
  logic [11:0] bmp_w = bbag_pkg::BITMAP_W_RST;
  logic [11:0] bmp_h = bbag_pkg::BITMAP_H_RST;
  logic        drawing = 1'b0;
  logic [11:0] org_x = '0, org_y = '0, span_c = '0, span_r = '0;
  logic [11:0] tile_c = '0, tile_r = '0, col_base = '0, row_start = '0;
  logic [11:0] row_cnt = '0, col_cnt = '0, tile_col = '0, tile_rw = '0;
  logic [23:0] row_addr = '0;

  // Length after clipping a span at the far edge; a negative start counts as zero.
  function automatic int clipped_len(int pos, int len, int limit);
    int p;
    p = (pos < 0) ? 0 : pos;
    return (p + len > limit) ? limit - p : len;
  endfunction

  function automatic int clipped_pos(int pos);
    return (pos < 0) ? 0 : pos;
  endfunction

  // Latch and clip a new draw; a start always cancels the draw in progress.
  task automatic start_blit(blit_cmd_t c);
    int dw, dh, sw, sh, cols, rows;
    dw = clipped_len(c.dl, c.dw, bbag_pkg::SCREEN_W);
    dh = clipped_len(c.dt, c.dh, bbag_pkg::SCREEN_H);
    sw = clipped_len(c.sl, c.sw, bmp_w);
    sh = clipped_len(c.st, c.sh, bmp_h);
    drawing = 1'b0;
    if ((c.mode == bbag_pkg::MODE_SOLID || c.mode == bbag_pkg::MODE_REPEAT) &&
        dw > 0 && dh > 0 && sw > 0 && sh > 0) begin
      if (c.mode == bbag_pkg::MODE_SOLID) begin
        cols = (dw < sw) ? dw : sw;
        rows = (dh < sh) ? dh : sh;
        tile_c = 12'(cols);
        tile_r = 12'(rows);
      end else begin
        cols = dw;
        rows = dh;
        tile_c = 12'(sw);
        tile_r = 12'(sh);
      end
      org_x     = 12'(clipped_pos(c.dl));
      org_y     = 12'(clipped_pos(c.dt));
      span_c    = 12'(cols);
      span_r    = 12'(rows);
      col_base  = 12'(clipped_pos(c.sl));
      row_start = 12'(clipped_pos(c.st));
      row_cnt   = '0;
      col_cnt   = '0;
      tile_col  = '0;
      tile_rw   = '0;
      row_addr  = {12'd0, row_start} * {12'd0, bmp_w};
      drawing   = 1'b1;
    end
  endtask

  // Apply one accepted command beat and queue the pixel it produces, if any.
  task automatic advance_blit(blit_cmd_t c);
    pixel_t px;
    if (c.cmd == bbag_pkg::CMD_START) begin
      start_blit(c);
    end else if (drawing) begin
      px.last = (int'(col_cnt) + 1 == int'(span_c)) && (int'(row_cnt) + 1 == int'(span_r));
      px.addr = row_addr + {12'd0, col_base} + {12'd0, tile_col};
      px.x    = org_x + col_cnt;
      px.y    = org_y + row_cnt;
      expected_pixels.push_back(px);
      if (px.last) begin
        drawing = 1'b0;
      end else begin
        col_cnt  = col_cnt + 12'd1;
        tile_col = tile_col + 12'd1;
        if (tile_col >= tile_c) begin
          tile_col = '0;
        end
        if (col_cnt >= span_c) begin
          col_cnt  = '0;
          tile_col = '0;
          row_cnt  = row_cnt + 12'd1;
          tile_rw  = tile_rw + 12'd1;
          if (tile_rw >= tile_r) begin
            tile_rw  = '0;
            row_addr = {12'd0, row_start} * {12'd0, bmp_w};
          end else begin
            row_addr = row_addr + {12'd0, bmp_w};
          end
        end
      end
    end
  endtask

  // Idle lengths: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 1;
    else if (r < 85) return $urandom_range(4, 2);
    else if (r < 96) return $urandom_range(12, 5);
    else return $urandom_range(60, 20);
  endfunction

  function automatic logic signed [11:0] sat12(int v);
    if (v > 2047) return 12'sd2047;
    else if (v < -2048) return -12'sd2048;
    else return 12'(v);
  endfunction

  // Rectangle start, often near the edges of the area it is clipped against.
  function automatic logic signed [11:0] pick_pos(int limit);
    int r;
    r = $urandom_range(99);
    if (r < 15) return sat12(-int'($urandom_range(6, 1)));
    else if (r < 30) return sat12(limit - int'($urandom_range(6)));
    else if (r < 90) return sat12(int'($urandom_range(limit - 1)));
    else return 12'($urandom);
  endfunction

  function automatic logic signed [11:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 75) return 12'($urandom_range(6, 1));
    else if (r < 85) return 12'($urandom_range(24, 7));
    else if (r < 93) return sat12(int'($urandom_range(3)) - 3);
    else return 12'($urandom);
  endfunction

  task automatic push_start(bbag_pkg::mode_e m, int dl, int dt, int dw, int dh,
                            int sl, int st, int sw, int sh);
    blit_cmd_t c;
    c.cmd  = bbag_pkg::CMD_START;
    c.mode = m;
    c.dl = 12'(dl); c.dt = 12'(dt); c.dw = 12'(dw); c.dh = 12'(dh);
    c.sl = 12'(sl); c.st = 12'(st); c.sw = 12'(sw); c.sh = 12'(sh);
    pending_cmds.push_back(c);
  endtask

  // Step beats carry random rectangle and mode bits, which the block must ignore.
  function automatic void push_steps(int n);
    blit_cmd_t c;
    repeat (n) begin
      c.cmd  = bbag_pkg::CMD_STEP;
      c.mode = bbag_pkg::mode_e'(2'($urandom));
      c.dl = 12'($urandom); c.dt = 12'($urandom);
      c.dw = 12'($urandom); c.dh = 12'($urandom);
      c.sl = 12'($urandom); c.st = 12'($urandom);
      c.sw = 12'($urandom); c.sh = 12'($urandom);
      pending_cmds.push_back(c);
    end
  endfunction

  // One random draw: a start, then steps; sometimes cut short by the next start,
  // sometimes followed by steps that land on an idle block. Returns the useful beats.
  function automatic int queue_draw();
    blit_cmd_t c;
    int r, dw, dh, sw, sh, total, n;
    r = $urandom_range(99);
    c.cmd  = bbag_pkg::CMD_START;
    if (r < 45) c.mode = bbag_pkg::MODE_SOLID;
    else if (r < 90) c.mode = bbag_pkg::MODE_REPEAT;
    else if (r < 95) c.mode = bbag_pkg::MODE_ADAPTIVE;
    else c.mode = bbag_pkg::MODE_NONE;
    c.dl = pick_pos(bbag_pkg::SCREEN_W); c.dt = pick_pos(bbag_pkg::SCREEN_H);
    c.dw = pick_len();                   c.dh = pick_len();
    c.sl = pick_pos(bmp_w);              c.st = pick_pos(bmp_h);
    c.sw = pick_len();                   c.sh = pick_len();
    pending_cmds.push_back(c);
    dw = clipped_len(c.dl, c.dw, bbag_pkg::SCREEN_W);
    dh = clipped_len(c.dt, c.dh, bbag_pkg::SCREEN_H);
    sw = clipped_len(c.sl, c.sw, bmp_w);
    sh = clipped_len(c.st, c.sh, bmp_h);
    if (c.mode == bbag_pkg::MODE_ADAPTIVE || c.mode == bbag_pkg::MODE_NONE ||
        dw <= 0 || dh <= 0 || sw <= 0 || sh <= 0) begin
      total = 0;
    end else if (c.mode == bbag_pkg::MODE_SOLID) begin
      total = ((dw < sw) ? dw : sw) * ((dh < sh) ? dh : sh);
    end else begin
      total = dw * dh;
    end
    n = (total > 40) ? $urandom_range(40, 5) : total;
    if ($urandom_range(99) < 12) begin
      n = $urandom_range(n);
    end
    push_steps(n);
    if ($urandom_range(99) < 15) begin
      push_steps($urandom_range(2, 1));
    end
    return n + 1;
  endfunction

  // Register write; the caller lowers the valid after its last write.
  task automatic cfg_write(logic [1:0] idx, logic [11:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == bbag_pkg::CFG_BITMAP_WIDTH) begin
      bmp_w = val;
    end else if (idx == bbag_pkg::CFG_BITMAP_HEIGHT) begin
      bmp_h = val;
    end
  endtask

  // Wait until every command is taken and every pixel has come back, then let a
  // possible trailing start beat finish.
  task automatic drain();
    do @(posedge clk_i);
    while (pending_cmds.size() != 0 || sender_busy || expected_pixels.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_field(string what, logic [23:0] got, logic [23:0] want);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Command driver: holds each beat until taken, with random gaps between beats.
  blit_cmd_t offered;
  int        send_gap = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        advance_blit(offered);
        sender_busy = 1'b0;
      end
      if (sender_busy) begin
        // Beat still waiting; keep it on the bus.
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        offered = pending_cmds.pop_front();
        command       <= offered.cmd;
        draw_mode     <= offered.mode;
        dest_left     <= offered.dl;
        dest_top      <= offered.dt;
        dest_width    <= offered.dw;
        dest_height   <= offered.dh;
        source_left   <= offered.sl;
        source_top    <= offered.st;
        source_width  <= offered.sw;
        source_height <= offered.sh;
        in_valid      <= 1'b1;
        sender_busy = 1'b1;
        if (!calm && $urandom_range(99) < 30) begin
          send_gap = pick_gap();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Pixel monitor: checks each beat in order and throttles the ready, with two
  // long hold-offs that back the block up into its command input.
  int pixel_beats = 0;
  int hold_left = 0;
  int stall_left = 0;

  always @(posedge clk_i) begin : pixel_monitor
    pixel_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        pixel_beats++;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel addr %0h x %0d y %0d", $time,
                   source_address_o, screen_x_o, screen_y_o);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("source_address", source_address_o, want.addr);
          check_field("screen_x", 24'(screen_x_o), 24'(want.x));
          check_field("screen_y", 24'(screen_y_o), 24'(want.y));
          check_field("last_pixel", 24'(last_pixel_o), 24'(want.last));
        end
        if (pixel_beats == 80 || pixel_beats == 500) begin
          hold_left = HOLD_OFF_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(99) < 25) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Stimulus: directed cases under the reset bitmap size, then random phases,
  // each under its own bitmap size.
  initial begin : stimulus
    int w_set[6];
    int h_set[6];
    int made;
    w_set = '{1, 4095, 13, 4095, 1, 0};
    h_set = '{1, 4095, 7, 1, 4095, 0};
    w_set[5] = $urandom_range(4095, 1);
    h_set[5] = $urandom_range(4095, 1);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    cfg_write(bbag_pkg::CFG_BITMAP_WIDTH, bbag_pkg::BITMAP_W_RST);
    cfg_write(bbag_pkg::CFG_BITMAP_HEIGHT, bbag_pkg::BITMAP_H_RST);
    cfg_valid <= 1'b0;

    // Step with no draw open.
    push_steps(1);
    // Solid copy with negative corners on both rectangles.
    push_start(bbag_pkg::MODE_SOLID, -3, -2, 2, 2, -1, -1, 3, 1);
    push_steps(2);
    // Repeat tile cut at the bottom right of screen and bitmap, plus a step after the end.
    push_start(bbag_pkg::MODE_REPEAT, 318, 238, 5, 5, 318, 238, 1, 3);
    push_steps(5);
    // Adaptive and none modes give nothing.
    push_start(bbag_pkg::MODE_ADAPTIVE, 0, 0, 4, 4, 0, 0, 4, 4);
    push_steps(1);
    push_start(bbag_pkg::MODE_NONE, 0, 0, 4, 4, 0, 0, 4, 4);
    push_steps(1);
    // Empty draw from a most negative width.
    push_start(bbag_pkg::MODE_SOLID, 10, 10, -2048, 2047, 0, 0, 4, 4);
    push_steps(1);
    // Full screen tile, aborted by a start whose rectangles clip to nothing.
    push_start(bbag_pkg::MODE_REPEAT, -2048, -2048, 2047, 2047, -2048, -2048, 2, 1);
    push_steps(3);
    push_start(bbag_pkg::MODE_SOLID, 2047, 2047, 4, 4, 2047, 2047, -2048, -2048);
    push_steps(1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0 || ph == 3) begin
        cfg_write(CFG_SPARE_A, 12'($urandom));
        cfg_write(CFG_SPARE_B, 12'($urandom));
      end
      cfg_write(bbag_pkg::CFG_BITMAP_WIDTH, 12'(w_set[ph]));
      cfg_write(bbag_pkg::CFG_BITMAP_HEIGHT, 12'(h_set[ph]));
      cfg_valid <= 1'b0;
      calm = (ph == 2);
      made = 0;
      while (made < 140) begin
        made += queue_draw();
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #12_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
